@@ hdl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising edge once reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true once reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hdl/gda_pkg.sv @@
package gda_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [15:0] DAY_CNT_MASK = 16'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [2:0] MODE_NEXT = 3'd0;
    localparam logic [2:0] MODE_PREV = 3'd1;
    localparam logic [2:0] MODE_ADD  = 3'd2;
    localparam logic [2:0] MODE_SUB  = 3'd3;
    localparam logic [2:0] MODE_DIST = 3'd4;
    localparam logic [2:0] MODE_CMP  = 3'd5;

    // Year first so that a plain vector compare orders dates in time.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic date_ok;
        logic at_edge;
    } t_step_stat;

    // Division by 100 through a reciprocal; exact for every 14-bit year.
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic        div100;
        logic        div400;
        prod   = 27'(y) * 27'(13'd5243);
        q      = prod[26:19];
        div100 = (15'(y) == 15'(15'(q) * 15'd100));
        div400 = div100 && (q[1:0] == 2'b00);
        return ((y[1:0] == 2'b00) && !div100) || div400;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/gda_step.sv @@
module gda_step import gda_pkg::*; (
    input  t_date      i_date,
    input  logic       i_leap,
    input  logic       i_bwd,
    output t_date      o_next,
    output t_step_stat o_stat
);

    logic [4:0] mlen;
    logic [4:0] prev_len;
    logic [3:0] prev_month;

    assign mlen       = month_len(i_date.month, i_leap);
    assign prev_month = (i_date.month == 4'd1) ? 4'd12 : i_date.month - 4'd1;
    assign prev_len   = month_len(prev_month, i_leap);

    assign o_stat.date_ok = (i_date.year <= YEAR_MAX) && (i_date.month >= 4'd1)
                          && (i_date.month <= 4'd12) && (i_date.day >= 5'd1)
                          && (i_date.day <= mlen);

    assign o_stat.at_edge = i_bwd
        ? ((i_date.year == 14'd0) && (i_date.month == 4'd1) && (i_date.day == 5'd1))
        : ((i_date.year == YEAR_MAX) && (i_date.month == 4'd12) && (i_date.day == 5'd31));

    always_comb begin
        o_next = i_date;
        if (!i_bwd) begin
            if (i_date.day == mlen) begin
                o_next.day = 5'd1;
                if (i_date.month == 4'd12) begin
                    o_next.month = 4'd1;
                    o_next.year  = i_date.year + 14'd1;
                end else begin
                    o_next.month = i_date.month + 4'd1;
                end
            end else begin
                o_next.day = i_date.day + 5'd1;
            end
        end else begin
            if (i_date.day == 5'd1) begin
                // Leaving January moves into December of the year before.
                o_next.month = prev_month;
                o_next.day   = prev_len;
                if (i_date.month == 4'd1) begin
                    o_next.year = i_date.year - 14'd1;
                end
            end else begin
                o_next.day = i_date.day - 5'd1;
            end
        end
    end

endmodule

@@ hdl/gregorian_date_arithmetic_top.sv @@
// Sequence from request to result: date A is checked; next and previous day, add and
// subtract then step the day; compare checks date B, and distance |A - B| walks to it.
// Throughput: one request at a time; the day stepper advances one day per cycle.
// Reset: synchronous, active low; it returns the sequencer to idle and drops any result.
module gregorian_date_arithmetic_top import gda_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_day_a,
    input  logic [3:0]  i_month_a,
    input  logic [13:0] i_year_a,
    input  logic [4:0]  i_day_b,
    input  logic [3:0]  i_month_b,
    input  logic [13:0] i_year_b,
    input  logic [15:0] i_day_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic [21:0] o_distance,
    output logic        o_a_greater,
    output logic        o_a_less,
    output logic        o_dates_equal,
    output logic        o_error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK_A = 3'd1;
    localparam logic [2:0] ST_CHK_B = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_DIST  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_mode, n_mode;
    t_date       r_a, n_a;
    t_date       r_b, n_b;
    t_date       r_w, n_w;
    t_date       r_tgt, n_tgt;
    logic        r_leap, n_leap;
    logic        r_fwd, n_fwd;
    logic [15:0] r_cnt, n_cnt;
    logic [21:0] r_dist, n_dist;
    logic        r_gt, n_gt;
    logic        r_lt, n_lt;
    logic        r_eq, n_eq;
    logic        r_err, n_err;

    t_date       step_next;
    t_step_stat  step_stat;
    logic        use_w;

    gda_step u_step (
        .i_date (r_w),
        .i_leap (r_leap),
        .i_bwd  (!r_fwd),
        .o_next (step_next),
        .o_stat (step_stat)
    );

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_a     = r_a;
        n_b     = r_b;
        n_w     = r_w;
        n_tgt   = r_tgt;
        n_fwd   = r_fwd;
        n_cnt   = r_cnt;
        n_dist  = r_dist;
        n_gt    = r_gt;
        n_lt    = r_lt;
        n_eq    = r_eq;
        n_err   = r_err;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_a     = '{year: i_year_a, month: i_month_a, day: i_day_a};
                    n_b     = '{year: i_year_b, month: i_month_b, day: i_day_b};
                    n_w     = '{year: i_year_a, month: i_month_a, day: i_day_a};
                    n_cnt   = i_day_count & DAY_CNT_MASK;
                    n_dist  = '0;
                    n_gt    = 1'b0;
                    n_lt    = 1'b0;
                    n_eq    = 1'b0;
                    n_err   = 1'b0;
                    n_state = ST_CHK_A;
                end
            end
            ST_CHK_A: begin
                n_fwd = (r_mode == MODE_NEXT) || (r_mode == MODE_ADD)
                     || (r_mode == MODE_DIST);
                if ((r_mode > MODE_CMP) || !step_stat.date_ok) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else if (r_mode <= MODE_SUB) begin
                    if ((r_mode == MODE_NEXT) || (r_mode == MODE_PREV)) begin
                        n_cnt = 16'd1;
                    end
                    n_state = ST_STEP;
                end else begin
                    n_w     = r_b;
                    n_state = ST_CHK_B;
                end
            end
            ST_CHK_B: begin
                if (!step_stat.date_ok) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_gt = (r_a > r_b);
                    n_lt = (r_a < r_b);
                    n_eq = (r_a == r_b);
                    if (r_mode == MODE_DIST) begin
                        // Walk the earlier date forward until it meets the later one.
                        n_w     = (r_a > r_b) ? r_b : r_a;
                        n_tgt   = (r_a > r_b) ? r_a : r_b;
                        n_fwd   = 1'b1;
                        n_state = ST_DIST;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_STEP: begin
                if (r_cnt == 16'd0) begin
                    n_state = ST_DONE;
                end else if (step_stat.at_edge) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_w   = step_next;
                    n_cnt = r_cnt - 16'd1;
                end
            end
            ST_DIST: begin
                if (r_w == r_tgt) begin
                    n_state = ST_DONE;
                end else begin
                    n_w    = step_next;
                    n_dist = r_dist + 22'd1;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // Leap flag always tracks the working year so the stepper sees it next cycle.
        n_leap = is_leap(n_w.year);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode <= n_mode;
        r_a    <= n_a;
        r_b    <= n_b;
        r_w    <= n_w;
        r_tgt  <= n_tgt;
        r_leap <= n_leap;
        r_fwd  <= n_fwd;
        r_cnt  <= n_cnt;
        r_dist <= n_dist;
        r_gt   <= n_gt;
        r_lt   <= n_lt;
        r_eq   <= n_eq;
        r_err  <= n_err;
    end

    assign use_w = (r_mode <= MODE_SUB) && !r_err;

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_DONE);
    assign o_day_out     = use_w ? r_w.day   : r_a.day;
    assign o_month_out   = use_w ? r_w.month : r_a.month;
    assign o_year_out    = use_w ? r_w.year  : r_a.year;
    assign o_distance    = r_dist;
    assign o_a_greater   = r_gt;
    assign o_a_less      = r_lt;
    assign o_dates_equal = r_eq;
    assign o_error       = r_err;

endmodule

@@ hdl/gda_checker.sv @@
`include "assert_macros.svh"

module gda_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_day_out,
    input logic [3:0]  o_month_out,
    input logic [13:0] o_year_out,
    input logic [21:0] o_distance,
    input logic        o_a_greater,
    input logic        o_a_less,
    input logic        o_dates_equal,
    input logic        o_error
);

    // A held result must not change until it is taken.
    `ASSERT_CLK(a_result_holds, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_day_out) && $stable(o_month_out)
        && $stable(o_year_out) && $stable(o_distance) && $stable(o_error),
        "result changed while stalled")

    // The unit works on one request at a time.
    `ASSERT_NEVER(a_one_in_flight, i_clk, i_rst_n, o_valid && o_ready,
        "ready while a result is pending")

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
        i_valid && o_ready |=> !o_ready, "ready right after a request")

    // At most one ordering flag, and none on an error.
    `ASSERT_CLK(a_order_flags, i_clk, i_rst_n,
        o_valid |-> $onehot0({o_a_greater, o_a_less, o_dates_equal}),
        "conflicting compare flags")

    `ASSERT_CLK(a_error_clean, i_clk, i_rst_n,
        o_valid && o_error |-> !o_a_greater && !o_a_less && !o_dates_equal
        && (o_distance == 22'd0),
        "flags or distance set with error")

endmodule

bind gregorian_date_arithmetic_top gda_checker u_gda_checker (.*);

@@ dv/gregorian_date_arithmetic_top_test.sv @@
`timescale 1ns / 1ps

module gregorian_date_arithmetic_top_test;
    import gda_pkg::*;

    // Mode codes the package leaves unnamed; the block must flag them.
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;
    localparam int unsigned MAX_GAP = 18;
    localparam int unsigned LAST_YEAR = 9999;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [15:0] day_count;
    } t_date_req;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [21:0] distance;
        logic        a_greater;
        logic        a_less;
        logic        dates_equal;
        logic        error;
    } t_date_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_mode;
    logic [4:0]  i_day_a;
    logic [3:0]  i_month_a;
    logic [13:0] i_year_a;
    logic [4:0]  i_day_b;
    logic [3:0]  i_month_b;
    logic [13:0] i_year_b;
    logic [15:0] i_day_count;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;
    logic [21:0] o_distance;
    logic        o_a_greater;
    logic        o_a_less;
    logic        o_dates_equal;
    logic        o_error;

    t_date_result predicted_results[$];
    int unsigned  mismatches = 0;
    bit           steady_flow = 1'b0;

    gregorian_date_arithmetic_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_day_a       (i_day_a),
        .i_month_a     (i_month_a),
        .i_year_a      (i_year_a),
        .i_day_b       (i_day_b),
        .i_month_b     (i_month_b),
        .i_year_b      (i_year_b),
        .i_day_count   (i_day_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_day_out     (o_day_out),
        .o_month_out   (o_month_out),
        .o_year_out    (o_year_out),
        .o_distance    (o_distance),
        .o_a_greater   (o_a_greater),
        .o_a_less      (o_a_less),
        .o_dates_equal (o_dates_equal),
        .o_error       (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #36_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------- calendar arithmetic ----------------

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_of_month(input int unsigned m, input int unsigned y);
        case (m)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic bit is_real_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
        if (y > LAST_YEAR || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= days_of_month(m, y);
    endfunction

    // Days from 0000-01-01 to January 1 of year y; year 0 is a leap year.
    function automatic int unsigned year_start(input int unsigned y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic int unsigned epoch_day(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
        int unsigned n;
        n = year_start(y);
        for (int unsigned k = 1; k < m; k++)
            n += days_of_month(k, y);
        return n + d - 1;
    endfunction

    function automatic t_date day_to_date(input int unsigned n);
        t_date       d;
        int unsigned y;
        int unsigned m;
        int unsigned rest;
        y = n / 366;
        while (y < LAST_YEAR && year_start(y + 1) <= n)
            y++;
        rest = n - year_start(y);
        m = 1;
        while (m < 12 && rest >= days_of_month(m, y)) begin
            rest -= days_of_month(m, y);
            m++;
        end
        d.year  = 14'(y);
        d.month = 4'(m);
        d.day   = 5'(rest + 1);
        return d;
    endfunction

    function automatic t_date_result predict_date_op(input t_date_req r);
        t_date_result res;
        int unsigned  na;
        int unsigned  nb;
        int unsigned  step;
        int unsigned  last;
        bit           fwd;
        t_date        moved;
        res       = '0;
        res.day   = r.day_a;
        res.month = r.month_a;
        res.year  = r.year_a;
        last = epoch_day(31, 12, LAST_YEAR);
        if (r.mode > MODE_CMP || !is_real_date(r.day_a, r.month_a, r.year_a)) begin
            res.error = 1'b1;
        end else if (r.mode <= MODE_SUB) begin
            na   = epoch_day(r.day_a, r.month_a, r.year_a);
            step = (r.mode == MODE_NEXT || r.mode == MODE_PREV) ? 1 : (r.day_count & DAY_CNT_MASK);
            fwd  = (r.mode == MODE_NEXT || r.mode == MODE_ADD);
            if (fwd ? (step > last - na) : (step > na)) begin
                res.error = 1'b1;
            end else begin
                moved     = day_to_date(fwd ? na + step : na - step);
                res.day   = moved.day;
                res.month = moved.month;
                res.year  = moved.year;
            end
        end else if (!is_real_date(r.day_b, r.month_b, r.year_b)) begin
            res.error = 1'b1;
        end else begin
            na = epoch_day(r.day_a, r.month_a, r.year_a);
            nb = epoch_day(r.day_b, r.month_b, r.year_b);
            res.a_greater   = na > nb;
            res.a_less      = na < nb;
            res.dates_equal = na == nb;
            if (r.mode == MODE_DIST)
                res.distance = 22'((na > nb) ? na - nb : nb - na);
        end
        return res;
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_date_req make_req(input logic [2:0] mode,
                                           input int unsigned da, input int unsigned ma,
                                           input int unsigned ya, input int unsigned db,
                                           input int unsigned mb, input int unsigned yb,
                                           input int unsigned cnt);
        t_date_req r;
        r.mode      = mode;
        r.day_a     = 5'(da);
        r.month_a   = 4'(ma);
        r.year_a    = 14'(ya);
        r.day_b     = 5'(db);
        r.month_b   = 4'(mb);
        r.year_b    = 14'(yb);
        r.day_count = 16'(cnt);
        return r;
    endfunction

    task automatic send_request(input t_date_req req);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= req.mode;
        i_day_a     <= req.day_a;
        i_month_a   <= req.month_a;
        i_year_a    <= req.year_a;
        i_day_b     <= req.day_b;
        i_month_b   <= req.month_b;
        i_year_b    <= req.year_b;
        i_day_count <= req.day_count;
        do @(posedge i_clk); while (!o_ready);
        predicted_results.push_back(predict_date_op(req));
    endtask

    // Years cluster at the range ends and on century boundaries.
    function automatic logic [13:0] pick_year();
        case ($urandom_range(0, 4))
            0:       return 14'($urandom_range(0, 3));
            1:       return 14'($urandom_range(9996, 9999));
            2:       return 14'($urandom_range(0, 99) * 100 + $urandom_range(0, 1));
            default: return 14'($urandom_range(0, 9999));
        endcase
    endfunction

    function automatic t_date pick_date();
        t_date       d;
        int unsigned len;
        d.year  = pick_year();
        d.month = 4'($urandom_range(1, 12));
        len = days_of_month(d.month, d.year);
        d.day = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
        return d;
    endfunction

    task automatic test_day_steps();
        send_request(make_req(MODE_NEXT, 28, 2, 2024, 1, 1, 0, 0));
        send_request(make_req(MODE_NEXT, 28, 2, 1900, 1, 1, 0, 0));
        send_request(make_req(MODE_NEXT, 31, 12, 1999, 1, 1, 0, 0));
        send_request(make_req(MODE_NEXT, 31, 12, 9999, 1, 1, 0, 0));
        send_request(make_req(MODE_PREV, 1, 1, 0, 1, 1, 0, 0));
        send_request(make_req(MODE_PREV, 1, 3, 2000, 1, 1, 0, 0));
        send_request(make_req(MODE_PREV, 1, 3, 0, 1, 1, 0, 16'hFFFF));
    endtask

    task automatic test_add_subtract();
        send_request(make_req(MODE_ADD, 1, 1, 0, 1, 1, 0, 16'hFFFF));
        send_request(make_req(MODE_SUB, 31, 12, 9999, 1, 1, 0, 16'hFFFF));
        send_request(make_req(MODE_ADD, 30, 12, 9999, 1, 1, 0, 2));
        send_request(make_req(MODE_SUB, 2, 1, 0, 1, 1, 0, 2));
        send_request(make_req(MODE_ADD, 15, 6, 2023, 1, 1, 0, 0));
    endtask

    task automatic test_distance();
        send_request(make_req(MODE_DIST, 1, 3, 800, 1, 1, 0, 0));
        send_request(make_req(MODE_DIST, 4, 7, 5000, 4, 7, 5000, 0));
        send_request(make_req(MODE_DIST, 1, 2, 1900, 1, 3, 1900, 0));
        send_request(make_req(MODE_DIST, 10, 10, 2010, 10, 13, 2010, 0));
    endtask

    task automatic test_compare();
        send_request(make_req(MODE_CMP, 2, 1, 2001, 31, 12, 2000, 0));
        send_request(make_req(MODE_CMP, 31, 5, 9999, 1, 6, 9999, 0));
        send_request(make_req(MODE_CMP, 29, 2, 2000, 29, 2, 2000, 0));
    endtask

    task automatic test_invalid_input();
        send_request(make_req(MODE_NEXT, 0, 5, 2020, 1, 1, 0, 0));
        send_request(make_req(MODE_PREV, 31, 4, 2023, 1, 1, 0, 0));
        send_request(make_req(MODE_NEXT, 29, 2, 1900, 1, 1, 0, 0));
        send_request(make_req(MODE_ADD, 10, 15, 2020, 1, 1, 0, 5));
        send_request(make_req(MODE_SUB, 10, 0, 2020, 1, 1, 0, 5));
        send_request(make_req(MODE_NEXT, 1, 1, 16383, 1, 1, 0, 0));
        send_request(make_req(MODE_RSVD_6, 1, 1, 2020, 1, 1, 2020, 0));
        send_request(make_req(MODE_RSVD_7, 1, 1, 2020, 1, 1, 2020, 0));
        send_request(make_req(MODE_CMP, 1, 1, 2020, 0, 1, 2020, 0));
    endtask

    // Mostly valid dates with random content; a share of raw noise on every field.
    task automatic test_random_mix();
        t_date_req req;
        t_date     a;
        t_date     b;
        int        yb;
        for (int i = 0; i < 72; i++) begin
            steady_flow = (i % 40) >= 30;
            if ($urandom_range(0, 99) < 12) begin
                req.mode      = 3'($urandom);
                req.day_a     = 5'($urandom);
                req.month_a   = 4'($urandom);
                req.year_a    = 14'($urandom);
                req.day_b     = 5'($urandom);
                req.month_b   = 4'($urandom);
                req.year_b    = 14'($urandom);
                req.day_count = 16'($urandom_range(0, 1023));
                // Keep noise distances short so the run stays bounded.
                if (req.mode == MODE_DIST)
                    req.year_b = req.year_a;
            end else begin
                a = pick_date();
                b = pick_date();
                req.mode      = 3'($urandom_range(MODE_NEXT, MODE_CMP));
                req.day_count = 16'($urandom);
                if (req.mode == MODE_ADD || req.mode == MODE_SUB) begin
                    req.day_count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 6000))
                                                                : 16'($urandom_range(0, 400));
                end
                if (req.mode == MODE_DIST) begin
                    yb = int'(a.year) + $urandom_range(0, 4) - 2;
                    if (yb < 0)
                        yb = 0;
                    if (yb > LAST_YEAR)
                        yb = LAST_YEAR;
                    b.year = 14'(yb);
                    if (b.day > days_of_month(b.month, b.year))
                        b.day = 5'(days_of_month(b.month, b.year));
                end
                if ($urandom_range(0, 7) == 0)
                    b = a;
                if ($urandom_range(0, 19) == 0)
                    b.day = 5'd0;
                req.day_a   = a.day;
                req.month_a = a.month;
                req.year_a  = a.year;
                req.day_b   = b.day;
                req.month_b = b.month;
                req.year_b  = b.year;
            end
            send_request(req);
        end
        steady_flow = 1'b0;
    endtask

    // ---------------- result side ----------------

    task automatic log_mismatch(input string msg);
        $display("[%0t] result mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    initial begin
        int unsigned stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_date_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_results.size() == 0) begin
                log_mismatch("result with no request outstanding");
            end else begin
                want = predicted_results.pop_front();
                compare_field("day_out", 32'(o_day_out), 32'(want.day));
                compare_field("month_out", 32'(o_month_out), 32'(want.month));
                compare_field("year_out", 32'(o_year_out), 32'(want.year));
                compare_field("distance", 32'(o_distance), 32'(want.distance));
                compare_field("a_greater", 32'(o_a_greater), 32'(want.a_greater));
                compare_field("a_less", 32'(o_a_less), 32'(want.a_less));
                compare_field("dates_equal", 32'(o_dates_equal), 32'(want.dates_equal));
                compare_field("error", 32'(o_error), 32'(want.error));
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_mode      <= MODE_NEXT;
        i_day_a     <= '0;
        i_month_a   <= '0;
        i_year_a    <= '0;
        i_day_b     <= '0;
        i_month_b   <= '0;
        i_year_b    <= '0;
        i_day_count <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_day_steps();
        test_add_subtract();
        test_distance();
        test_compare();
        test_invalid_input();
        test_random_mix();

        i_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
